[hdl/oriented_rect_overlap_test_macros.svh]
// Assertion macros for the oriented rectangle overlap test
`ifndef ORIENTED_RECT_OVERLAP_TEST_MACROS_SVH
`define ORIENTED_RECT_OVERLAP_TEST_MACROS_SVH
`ifndef SYNTHESIS
`define OBB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("obb implication check failed");
`define OBB_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("obb next-cycle check failed");
`else
`define OBB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OBB_ASSERT_NXT(lbl, clk, ante, cons)
`endif
`endif

[hdl/obb_pkg.sv]
// Shared constants and types for the oriented rectangle overlap test
`default_nettype none
package obb_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 12;
    localparam int PHASE_W        = 16;
    localparam int TRIG_W         = 16;
    localparam int TRIG_FRAC      = 14;
    localparam int TRIG_ONE       = 16384;
    localparam int POLY_A         = 25736;
    localparam int POLY_B         = 10512;
    localparam int POLY_C         = 1160;
    localparam int NUM_AXES       = 4;
    localparam int NUM_STAGES     = 9;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_trig_adv;

    typedef struct packed {
        logic s7;
        logic s8;
        logic s9;
    } t_sat_adv;
endpackage
`default_nettype wire

[hdl/oriented_rect_overlap_test.sv]
// Oriented rectangle overlap test: nine-stage pipelined separating axis test.
// Throughput: one transaction per cycle unless i_stall holds the output; the
// four-product trig chain and the projection multipliers each sit in their own stages.
// Reset: synchronous active-low i_rst_n clears all stage valid bits;
// data registers are not reset.
`default_nettype none
`include "oriented_rect_overlap_test_macros.svh"
module oriented_rect_overlap_test #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = obb_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [COORD_BITS-1:0] i_a_left,
    input  wire logic signed [COORD_BITS-1:0] i_a_top,
    input  wire logic [COORD_BITS-1:0]        i_a_width,
    input  wire logic [COORD_BITS-1:0]        i_a_height,
    input  wire logic [ANGLE_BITS-1:0]        i_a_angle,
    input  wire logic signed [COORD_BITS-1:0] i_b_left,
    input  wire logic signed [COORD_BITS-1:0] i_b_top,
    input  wire logic [COORD_BITS-1:0]        i_b_width,
    input  wire logic [COORD_BITS-1:0]        i_b_height,
    input  wire logic [ANGLE_BITS-1:0]        i_b_angle,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_overlap
);
    import obb_pkg::*;

    localparam int VW = COORD_BITS + 17;
    localparam int DW = COORD_BITS + 3;
    localparam int GD = 5;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] adv;
    t_trig_adv             trig_adv;
    t_sat_adv              sat_adv;

    logic signed [TRIG_W-1:0] sa, ca, sb, cb;
    logic signed [DW-1:0]     n_dx, n_dy;
    logic signed [DW-1:0]     r_dx [GD];
    logic signed [DW-1:0]     r_dy [GD];
    logic [COORD_BITS-1:0]    r_aw [GD];
    logic [COORD_BITS-1:0]    r_ah [GD];
    logic [COORD_BITS-1:0]    r_bw [GD];
    logic [COORD_BITS-1:0]    r_bh [GD];

    logic signed [VW-1:0]     r_vx [NUM_AXES];
    logic signed [VW-1:0]     r_vy [NUM_AXES];
    logic signed [TRIG_W-1:0] r_ux [NUM_AXES];
    logic signed [TRIG_W-1:0] r_uy [NUM_AXES];
    logic signed [DW-1:0]     r_dx6, r_dy6;
    logic [NUM_AXES-1:0]      r_live6;
    logic signed [VW-1:0]     ah_s, aw_s, bh_s, bw_s;

    // each stage loads when empty or when the stage ahead moves
    always_comb begin
        adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES-2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign trig_adv = '{s1: adv[0], s2: adv[1], s3: adv[2], s4: adv[3], s5: adv[4]};
    assign sat_adv  = '{s7: adv[6], s8: adv[7], s9: adv[8]};
    assign o_stall  = !adv[0];
    assign o_valid  = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    obb_trig #(.ANGLE_BITS(ANGLE_BITS)) u_sin_a (
        .i_clk(i_clk), .i_angle(i_a_angle), .i_cos(1'b0), .i_adv(trig_adv), .o_trig(sa));
    obb_trig #(.ANGLE_BITS(ANGLE_BITS)) u_cos_a (
        .i_clk(i_clk), .i_angle(i_a_angle), .i_cos(1'b1), .i_adv(trig_adv), .o_trig(ca));
    obb_trig #(.ANGLE_BITS(ANGLE_BITS)) u_sin_b (
        .i_clk(i_clk), .i_angle(i_b_angle), .i_cos(1'b0), .i_adv(trig_adv), .o_trig(sb));
    obb_trig #(.ANGLE_BITS(ANGLE_BITS)) u_cos_b (
        .i_clk(i_clk), .i_angle(i_b_angle), .i_cos(1'b1), .i_adv(trig_adv), .o_trig(cb));

    // doubled center distance, exact in DW bits
    always_comb begin
        n_dx = ((DW'(i_a_left) - DW'(i_b_left)) <<< 1) + DW'(i_a_width) - DW'(i_b_width);
        n_dy = ((DW'(i_a_top) - DW'(i_b_top)) <<< 1) + DW'(i_a_height) - DW'(i_b_height);
        ah_s = VW'(r_ah[GD-1]);
        aw_s = VW'(r_aw[GD-1]);
        bh_s = VW'(r_bh[GD-1]);
        bw_s = VW'(r_bw[GD-1]);
    end

    // hold geometry alongside the trig stages
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_dx[0] <= n_dx;
            r_dy[0] <= n_dy;
            r_aw[0] <= i_a_width;
            r_ah[0] <= i_a_height;
            r_bw[0] <= i_b_width;
            r_bh[0] <= i_b_height;
        end
        for (int k = 1; k < GD; k++) begin
            if (adv[k]) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
                r_aw[k] <= r_aw[k-1];
                r_ah[k] <= r_ah[k-1];
                r_bw[k] <= r_bw[k-1];
                r_bh[k] <= r_bh[k-1];
            end
        end
        if (adv[5]) begin
            // axes: A height, B height, A width, B width
            r_vx[0] <= ah_s * VW'(sa);
            r_vy[0] <= -(ah_s * VW'(ca));
            r_vx[1] <= bh_s * VW'(sb);
            r_vy[1] <= -(bh_s * VW'(cb));
            r_vx[2] <= aw_s * VW'(ca);
            r_vy[2] <= aw_s * VW'(sa);
            r_vx[3] <= bw_s * VW'(cb);
            r_vy[3] <= bw_s * VW'(sb);
            r_ux[0] <= sa;
            r_uy[0] <= -ca;
            r_ux[1] <= sb;
            r_uy[1] <= -cb;
            r_ux[2] <= ca;
            r_uy[2] <= sa;
            r_ux[3] <= cb;
            r_uy[3] <= sb;
            r_dx6   <= r_dx[GD-1];
            r_dy6   <= r_dy[GD-1];
            r_live6 <= {r_bw[GD-1] != '0, r_aw[GD-1] != '0,
                        r_bh[GD-1] != '0, r_ah[GD-1] != '0};
        end
    end

    obb_sat #(.COORD_BITS(COORD_BITS)) u_sat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (sat_adv),
        .i_vld8    (r_vld[7]),
        .i_vx      (r_vx),
        .i_vy      (r_vy),
        .i_ux      (r_ux),
        .i_uy      (r_uy),
        .i_dx      (r_dx6),
        .i_dy      (r_dy6),
        .i_live    (r_live6),
        .o_overlap (o_overlap)
    );

    `OBB_ASSERT_NXT(a_reset_clears, i_clk, (!i_rst_n), (!o_valid))
    `OBB_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, (o_stall), (r_vld == '1 && i_stall))
endmodule
`default_nettype wire

[hdl/obb_trig.sv]
// Five-stage sine/cosine unit using a quarter-wave polynomial
`default_nettype none
module obb_trig #(
    parameter int ANGLE_BITS = obb_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic [ANGLE_BITS-1:0]                 i_angle,
    input  wire logic                                  i_cos,
    input  wire obb_pkg::t_trig_adv                    i_adv,
    output logic signed [obb_pkg::TRIG_W-1:0]          o_trig
);
    import obb_pkg::*;

    logic [PHASE_W-1:0] phase;
    logic [14:0]        n_t;
    logic [14:0]        r_t1, r_t2, r_t3, r_t4;
    logic [14:0]        r_sq2, r_sq3;
    logic [15:0]        r_k3, r_m4;
    logic               r_neg1, r_neg2, r_neg3, r_neg4;
    logic [31:0]        prod5;
    logic [14:0]        mag5;
    logic signed [TRIG_W-1:0] r_trig;

    always_comb begin
        phase = (PHASE_W'(i_angle) << (PHASE_W - ANGLE_BITS))
              + (i_cos ? PHASE_W'(TRIG_ONE) : PHASE_W'(0));
        // mirror odd quadrants
        n_t = phase[TRIG_FRAC] ? 15'(TRIG_ONE - int'(phase[TRIG_FRAC-1:0]))
                               : 15'(phase[TRIG_FRAC-1:0]);
        prod5 = (32'(r_t4) * 32'(r_m4)) >> TRIG_FRAC;
        mag5  = (prod5 > 32'(TRIG_ONE)) ? 15'(TRIG_ONE) : 15'(prod5);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_t1   <= n_t;
            r_neg1 <= phase[PHASE_W-1];
        end
        if (i_adv.s2) begin
            r_sq2  <= 15'((30'(r_t1) * 30'(r_t1)) >> TRIG_FRAC);
            r_t2   <= r_t1;
            r_neg2 <= r_neg1;
        end
        if (i_adv.s3) begin
            r_k3   <= 16'(POLY_B) - 16'((32'(POLY_C) * 32'(r_sq2)) >> TRIG_FRAC);
            r_sq3  <= r_sq2;
            r_t3   <= r_t2;
            r_neg3 <= r_neg2;
        end
        if (i_adv.s4) begin
            r_m4   <= 16'(POLY_A) - 16'((32'(r_sq3) * 32'(r_k3)) >> TRIG_FRAC);
            r_t4   <= r_t3;
            r_neg4 <= r_neg3;
        end
        if (i_adv.s5) begin
            r_trig <= r_neg4 ? -$signed(TRIG_W'(mag5)) : $signed(TRIG_W'(mag5));
        end
    end

    assign o_trig = r_trig;
endmodule
`default_nettype wire

[hdl/obb_sat.sv]
// Projection, summation and compare stages of the separating axis test
`default_nettype none
`include "oriented_rect_overlap_test_macros.svh"
module obb_sat #(
    parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire obb_pkg::t_sat_adv                      i_adv,
    input  wire logic                                   i_vld8,
    input  wire logic signed [COORD_BITS+16:0]          i_vx [obb_pkg::NUM_AXES],
    input  wire logic signed [COORD_BITS+16:0]          i_vy [obb_pkg::NUM_AXES],
    input  wire logic signed [obb_pkg::TRIG_W-1:0]      i_ux [obb_pkg::NUM_AXES],
    input  wire logic signed [obb_pkg::TRIG_W-1:0]      i_uy [obb_pkg::NUM_AXES],
    input  wire logic signed [COORD_BITS+2:0]           i_dx,
    input  wire logic signed [COORD_BITS+2:0]           i_dy,
    input  wire logic [obb_pkg::NUM_AXES-1:0]           i_live,
    output logic                                        o_overlap
);
    import obb_pkg::*;

    localparam int VW = COORD_BITS + 17;
    localparam int DW = COORD_BITS + 3;
    localparam int PW = VW + TRIG_W;
    localparam int QW = DW + TRIG_W;
    localparam int SW = PW + 3;

    logic signed [PW-1:0] r_px [NUM_AXES][NUM_AXES];
    logic signed [PW-1:0] r_py [NUM_AXES][NUM_AXES];
    logic signed [QW-1:0] r_qx [NUM_AXES];
    logic signed [QW-1:0] r_qy [NUM_AXES];
    logic [NUM_AXES-1:0]  r_live7, r_live8;
    logic [SW-1:0]        n_sum [NUM_AXES];
    logic [SW-1:0]        n_dist [NUM_AXES];
    logic [SW-1:0]        r_sum [NUM_AXES];
    logic [SW-1:0]        r_dist [NUM_AXES];
    logic signed [PW:0]   dot [NUM_AXES][NUM_AXES];
    logic signed [QW:0]   ddot [NUM_AXES];
    logic [PW:0]          adot [NUM_AXES][NUM_AXES];
    logic [QW:0]          addot [NUM_AXES];
    logic [NUM_AXES-1:0]  sep;
    logic                 r_overlap;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n_sum[i] = '0;
            for (int j = 0; j < NUM_AXES; j++) begin
                dot[i][j]  = (PW+1)'(r_px[i][j]) + (PW+1)'(r_py[i][j]);
                adot[i][j] = dot[i][j][PW] ? (PW+1)'(-dot[i][j]) : (PW+1)'(dot[i][j]);
                n_sum[i]   = n_sum[i] + SW'(adot[i][j]);
            end
            ddot[i]   = (QW+1)'(r_qx[i]) + (QW+1)'(r_qy[i]);
            addot[i]  = ddot[i][QW] ? (QW+1)'(-ddot[i]) : (QW+1)'(ddot[i]);
            n_dist[i] = SW'(addot[i]) << TRIG_FRAC;
            sep[i]    = r_live8[i] && (r_dist[i] > r_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s7) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                for (int j = 0; j < NUM_AXES; j++) begin
                    r_px[i][j] <= PW'(i_vx[j]) * PW'(i_ux[i]);
                    r_py[i][j] <= PW'(i_vy[j]) * PW'(i_uy[i]);
                end
                r_qx[i] <= QW'(i_dx) * QW'(i_ux[i]);
                r_qy[i] <= QW'(i_dy) * QW'(i_uy[i]);
            end
            r_live7 <= i_live;
        end
        if (i_adv.s8) begin
            r_sum   <= n_sum;
            r_dist  <= n_dist;
            r_live8 <= r_live7;
        end
        if (i_adv.s9) begin
            r_overlap <= ~|sep;
        end
    end

    assign o_overlap = r_overlap;

    `OBB_ASSERT_IMP(a_sep_needs_live, i_clk, i_rst_n, (sep != '0), ((sep & ~r_live8) == '0))
    `OBB_ASSERT_NXT(a_no_axes_overlap, i_clk, (i_rst_n && i_adv.s9 && i_vld8 && r_live8 == '0), (r_overlap))
endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the oriented rectangle overlap pipeline
`default_nettype none
module tb;
    localparam int CW = 16;
    localparam int AW = 12;
    localparam int LATENCY = obb_pkg::NUM_STAGES;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [CW-1:0] al, at, bl, bt;
        logic [CW-1:0] aw, ah, bw, bh;
        logic [AW-1:0] aa, ba;
    } t_rect_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_overlap;
    logic signed [CW-1:0] i_a_left = '0, i_a_top = '0, i_b_left = '0, i_b_top = '0;
    logic [CW-1:0] i_a_width = '0, i_a_height = '0, i_b_width = '0, i_b_height = '0;
    logic [AW-1:0] i_a_angle = '0, i_b_angle = '0;

    t_rect_pair pending_pairs[$];
    logic expected_overlap[$];
    int error_count = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;
    bit hold_off = 1'b0;
    bit drain_pause = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    always #5 i_clk = ~i_clk;

    oriented_rect_overlap_test u_top (.*);

    function automatic longint quarter_wave(longint t);
        longint t2, k, m, r;
        t2 = (t * t) >>> 14;
        k = obb_pkg::POLY_B - ((obb_pkg::POLY_C * t2) >>> 14);
        m = obb_pkg::POLY_A - ((t2 * k) >>> 14);
        r = (t * m) >>> 14;
        if (r > obb_pkg::TRIG_ONE) r = obb_pkg::TRIG_ONE;
        if (r < 0) r = 0;
        return r;
    endfunction

    function automatic longint sine_q14(logic [15:0] phase);
        logic [13:0] x;
        longint mag;
        x = phase[13:0];
        mag = phase[14] ? quarter_wave(obb_pkg::TRIG_ONE - x) : quarter_wave(x);
        return phase[15] ? -mag : mag;
    endfunction

    function automatic longint abs_proj(longint vx, longint vy, longint ux, longint uy);
        longint d;
        d = vx * ux + vy * uy;
        return d < 0 ? -d : d;
    endfunction

    function automatic logic predict_overlap(t_rect_pair p);
        logic [15:0] pa, pb;
        longint sa, ca, sb, cb, dx, dy, sum, proj_dist;
        longint ux[4], uy[4], vx[4], vy[4];
        bit live[4];
        pa = {p.aa, 4'b0};
        pb = {p.ba, 4'b0};
        sa = sine_q14(pa);
        ca = sine_q14(pa + 16'h4000);
        sb = sine_q14(pb);
        cb = sine_q14(pb + 16'h4000);
        dx = 2 * (longint'(p.al) - longint'(p.bl)) + longint'(p.aw) - longint'(p.bw);
        dy = 2 * (longint'(p.at) - longint'(p.bt)) + longint'(p.ah) - longint'(p.bh);
        ux[0] = sa; uy[0] = -ca; live[0] = p.ah != 0;
        ux[1] = sb; uy[1] = -cb; live[1] = p.bh != 0;
        ux[2] = ca; uy[2] = sa;  live[2] = p.aw != 0;
        ux[3] = cb; uy[3] = sb;  live[3] = p.bw != 0;
        vx[0] = p.ah * sa; vy[0] = -longint'(p.ah) * ca;
        vx[1] = p.bh * sb; vy[1] = -longint'(p.bh) * cb;
        vx[2] = p.aw * ca; vy[2] = p.aw * sa;
        vx[3] = p.bw * cb; vy[3] = p.bw * sb;
        for (int i = 0; i < 4; i++) begin
            if (!live[i]) continue;
            sum = 0;
            for (int j = 0; j < 4; j++) sum += abs_proj(vx[j], vy[j], ux[i], uy[i]);
            proj_dist = abs_proj(dx, dy, ux[i], uy[i]) <<< 14;
            if (proj_dist > sum) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_rect_pair random_pair(bit near);
        t_rect_pair p;
        int sel;
        sel = $urandom_range(0, 9);
        p.aa = AW'($urandom); p.ba = AW'($urandom);
        if (near) begin
            // keep sizes and offsets comparable so both outcomes are common
            p.aw = CW'($urandom_range(0, 2048)); p.ah = CW'($urandom_range(0, 2048));
            p.bw = CW'($urandom_range(0, 2048)); p.bh = CW'($urandom_range(0, 2048));
            p.al = CW'($urandom_range(0, 4096) - 2048);
            p.at = CW'($urandom_range(0, 4096) - 2048);
            p.bl = p.al + $signed(CW'($urandom_range(0, 4096) - 2048));
            p.bt = p.at + $signed(CW'($urandom_range(0, 4096) - 2048));
            if (sel == 0) p.aw = '0;
            if (sel == 1) p.bh = '0;
        end else begin
            p.al = CW'($urandom); p.at = CW'($urandom);
            p.bl = CW'($urandom); p.bt = CW'($urandom);
            p.aw = CW'($urandom); p.ah = CW'($urandom);
            p.bw = CW'($urandom); p.bh = CW'($urandom);
        end
        return p;
    endfunction

    function automatic t_rect_pair make_pair(int al, int at, int aw, int ah, int aa,
                                             int bl, int bt, int bw, int bh, int ba);
        t_rect_pair p;
        p.al = CW'(al); p.at = CW'(at); p.aw = CW'(aw); p.ah = CW'(ah); p.aa = AW'(aa);
        p.bl = CW'(bl); p.bt = CW'(bt); p.bw = CW'(bw); p.bh = CW'(bh); p.ba = AW'(ba);
        return p;
    endfunction

    // driver: bursts and gaps; hold payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_overlap.push_back(predict_overlap(pending_pairs.pop_front()));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() > 0 && !drain_pause
                             && !(i_valid && !o_stall && pending_pairs.size() == 0)) begin
                    i_a_left <= pending_pairs[0].al;  i_a_top <= pending_pairs[0].at;
                    i_a_width <= pending_pairs[0].aw; i_a_height <= pending_pairs[0].ah;
                    i_a_angle <= pending_pairs[0].aa; i_b_left <= pending_pairs[0].bl;
                    i_b_top <= pending_pairs[0].bt;   i_b_width <= pending_pairs[0].bw;
                    i_b_height <= pending_pairs[0].bh; i_b_angle <= pending_pairs[0].ba;
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off window
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_off) i_stall <= 1'b1;
        else begin
            case ($urandom_range(0, 3))
                0: i_stall <= ($urandom_range(0, 1) == 1);
                1: i_stall <= ($urandom_range(0, 5) == 0);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // monitor: check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_overlap.size() == 0) begin
                    $error("unexpected result transaction: overlap=%0b", o_overlap);
                    error_count <= error_count + 1;
                end else begin
                    if (o_overlap !== expected_overlap[0]) begin
                        $error("overlap mismatch: expected %0b actual %0b",
                               expected_overlap[0], o_overlap);
                        error_count <= error_count + 1;
                    end
                    void'(expected_overlap.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        t_rect_pair p;
        // directed: extremes, zero sizes, touching, angle corners
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 32767, 32767, 0, 0, 0));
        pending_pairs.push_back(make_pair(-32768, -32768, 65535, 65535, 4095,
                                          32767, 32767, 65535, 65535, 4095));
        pending_pairs.push_back(make_pair(-32768, -32768, 16, 16, 0, 32767, 32767, 16, 16, 0));
        pending_pairs.push_back(make_pair(0, 0, 160, 160, 0, 160, 0, 160, 160, 0));
        pending_pairs.push_back(make_pair(0, 0, 160, 160, 0, 161, 0, 160, 160, 0));
        pending_pairs.push_back(make_pair(0, 0, 160, 160, 0, 0, 160, 160, 160, 0));
        pending_pairs.push_back(make_pair(0, 0, 160, 160, 1024, 100, 100, 160, 160, 2048));
        pending_pairs.push_back(make_pair(0, 0, 320, 32, 512, 200, 200, 32, 320, 3072));
        pending_pairs.push_back(make_pair(0, 0, 0, 160, 0, 300, 0, 160, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, 0, 300, 0, 160, 0));
        pending_pairs.push_back(make_pair(0, 0, 65535, 0, 1, 0, 0, 0, 65535, 4094));
        pending_pairs.push_back(make_pair(32767, -32768, 1, 1, 2047, -32768, 32767, 1, 1, 2049));
        pending_pairs.push_back(make_pair(100, 100, 400, 400, 3072, 150, 150, 50, 50, 1));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < 1836; n++) begin
            p = random_pair($urandom_range(0, 4) != 0);
            pending_pairs.push_back(p);
            if (n == 600) begin
                // long receiver hold-off while the sender keeps offering
                hold_off = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            if (n == 1200) begin
                // sender pauses until every outstanding result has come back
                drain_pause = 1'b1;
                @(posedge i_clk);
                while (i_valid || expected_overlap.size() > 0) @(posedge i_clk);
                repeat (LATENCY) @(posedge i_clk);
                drain_pause = 1'b0;
            end
        end
        while (pending_pairs.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_overlap.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (error_count == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/obb_pkg.sv
hdl/obb_trig.sv
hdl/obb_sat.sv
hdl/oriented_rect_overlap_test.sv
dv/tb.sv
